@@ hw/rtl/fstba_pkg.sv @@
// ----------------------------------------------------------------------------
// fstba_pkg
// Shared types, constants and helpers of the file slot table and allocator.
// ----------------------------------------------------------------------------
package fstba_pkg;

	localparam int NUM_BLOCKS  = 4096;
	localparam int BLOCK_BYTES = 4096;
	localparam int SLOTS       = 64;

	localparam int BB_LOG  = $clog2(BLOCK_BYTES);
	localparam int WORD_W  = 64;
	localparam int WOFF_W  = $clog2(WORD_W);
	localparam int CNT_W   = WOFF_W + 1;
	localparam int WORDS   = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BI_W    = $clog2(NUM_BLOCKS) + 1;
	localparam int SA_W    = $clog2(SLOTS);
	localparam int NEED_W  = 26 - BB_LOG;
	localparam int SUM_W   = ((NEED_W > BI_W) ? NEED_W : BI_W) + 1;

	localparam int KIND_W  = 3;
	localparam int BYTES_W = 25;
	localparam int BLK_W   = 12;
	localparam int INODE_W = 32;
	localparam int SLOT_W  = 6;
	localparam int STAT_W  = 3;
	localparam int ADDR_W  = 48;
	localparam int REFS_W  = 16;

	typedef enum logic [KIND_W-1:0] {
		K_ALLOC    = 3'd0,
		K_ADD_FILE = 3'd1,
		K_ADD_REF  = 3'd2,
		K_CLOSE    = 3'd3,
		K_READ     = 3'd4
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_SPACE   = 3'd1,
		ST_FULL       = 3'd2,
		ST_REFERENCED = 3'd3,
		ST_INVALID    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SLOT,
		S_RNG_RD,
		S_RNG_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic            rd_en;
		logic [WA_W-1:0] rd_addr;
		logic            wr_en;
		logic [WA_W-1:0] wr_addr;
	} bm_ctl_t;

	typedef struct packed {
		logic [INODE_W-1:0] inode;
		logic [BLK_W-1:0]   start;
		logic [BYTES_W-1:0] bytes;
		logic [REFS_W-1:0]  refs;
	} slot_entry_t;

	typedef struct packed {
		status_t            status;
		logic [BLK_W-1:0]   found_block;
		logic [ADDR_W-1:0]  buffer_address;
		logic [SLOT_W-1:0]  slot_taken;
		logic [INODE_W-1:0] slot_inode;
		logic [BYTES_W-1:0] slot_bytes;
		logic [REFS_W-1:0]  slot_refs;
		logic               slot_in_use;
	} result_t;

	// Number of blocks covering a byte count; an empty file still takes one.
	function automatic logic [NEED_W-1:0] blocks_for(input logic [BYTES_W-1:0] bytes);
		logic [BYTES_W:0] sum;
		logic [NEED_W-1:0] n;
		sum = {1'b0, bytes} + (BYTES_W+1)'(BLOCK_BYTES - 1);
		n = NEED_W'(sum >> BB_LOG);
		return (n == '0) ? NEED_W'(1) : n;
	endfunction

endpackage

@@ hw/rtl/fstba_if.sv @@
// ----------------------------------------------------------------------------
// fstba_req_if / fstba_rsp_if
// Valid/ready channels for requests and results of the slot table.
// ----------------------------------------------------------------------------
interface fstba_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [24:0] byte_size;
	logic [11:0] start_block;
	logic [31:0] inode;
	logic [5:0]  slot_index;

	modport source(output valid, kind, byte_size, start_block, inode, slot_index,
		input ready);
	modport sink(input valid, kind, byte_size, start_block, inode, slot_index,
		output ready);
endinterface

interface fstba_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [11:0] found_block;
	logic [47:0] buffer_address;
	logic [5:0]  slot_taken;
	logic [31:0] slot_inode;
	logic [24:0] slot_bytes;
	logic [15:0] slot_refs;
	logic        slot_in_use;

	modport source(output valid, status, found_block, buffer_address, slot_taken,
		slot_inode, slot_bytes, slot_refs, slot_in_use, input ready);
	modport sink(input valid, status, found_block, buffer_address, slot_taken,
		slot_inode, slot_bytes, slot_refs, slot_in_use, output ready);
endinterface

@@ hw/rtl/fstba_bmap.sv @@
// ----------------------------------------------------------------------------
// fstba_bmap
// Block occupancy bitmap: one word per row, registered read, row valid bits.
// ----------------------------------------------------------------------------
module fstba_bmap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fstba_pkg::bm_ctl_t            ctl,
	input  logic [fstba_pkg::WORD_W-1:0]  wr_data,
	output logic [fstba_pkg::WORD_W-1:0]  rd_data
);
	import fstba_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]  row_valid_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_valid_q;

	// A row never written since reset reads as all free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				row_valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= row_valid_q[ctl.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

@@ hw/rtl/file_slot_table_with_block_allocator.sv @@
// ----------------------------------------------------------------------------
// file_slot_table_with_block_allocator
// Slot table of open files with a first-fit contiguous block allocator.
// Alloc scans one bitmap word per cycle behind a registered read, then reads and
// writes back each bitmap word marked, and posts the result. Add file goes
// straight to posting; a slot kind first passes S_SLOT (an invalid slot does not),
// and a last close then reads and writes back each word freed; unknown kinds give
// no result. One item at a time, and posting waits while an earlier result is still unread.
// Reset clears the bitmap and the slot valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module file_slot_table_with_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [47:0] cfg_wdata,
	fstba_req_if.sink   req,
	fstba_rsp_if.source rsp
);
	import fstba_pkg::*;

	state_t state_q, state_d;

	logic [ADDR_W-1:0]  base_q;
	kind_t              kind_q;
	logic [SA_W-1:0]    slot_q;
	logic [NEED_W-1:0]  need_q;
	logic [NEED_W-1:0]  run_q;
	logic [BI_W-1:0]    rstart_q;
	logic [WA_W:0]      issue_q;
	logic               pv_s1;
	logic [WA_W-1:0]    pw_s1;
	logic [SUM_W-1:0]   lo_q, hi_q;
	logic               set_q;
	logic [WA_W-1:0]    rw_q;
	result_t            res_q, out_q;
	result_t            idle_res;
	logic               out_v_q;

	logic [SLOTS-1:0]   sv_q;
	slot_entry_t        slot_mem [SLOTS];
	slot_entry_t        slot_rd_q;
	logic               slot_we;
	logic [SA_W-1:0]    slot_wa;
	slot_entry_t        slot_wd;

	bm_ctl_t            bm_ctl;
	logic [WORD_W-1:0]  bm_rd, bm_wd;

	logic               accept;
	logic               free_found;
	logic [SA_W-1:0]    free_slot;
	logic               slot_ok;

	logic [WORD_W-1:0]  free_w;
	logic [CNT_W-1:0]   tz, lz;
	logic               win_hit;
	logic [WOFF_W-1:0]  win_pos;
	logic [WORD_W:0]    nmask;
	logic [BI_W-1:0]    word_base;
	logic               scan_found;
	logic [BI_W-1:0]    scan_start;
	logic               scan_last;

	logic [REFS_W-1:0]  refs_dec;
	logic               last_close;
	logic [SUM_W-1:0]   close_hi;

	logic [WA_W-1:0]    lo_w, hi_w;
	logic [CNT_W-1:0]   lo_off, hi_off;
	logic [WORD_W:0]    rmask;
	logic               rng_last;

	fstba_bmap u_bmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (bm_ctl),
		.wr_data (bm_wd),
		.rd_data (bm_rd)
	);

	assign accept  = req.valid && req.ready;
	assign slot_ok = (int'(req.slot_index) < SLOTS) && sv_q[SA_W'(req.slot_index)];

	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (!sv_q[s]) begin
				free_found = 1'b1;
				free_slot  = SA_W'(s);
			end
		end
	end

	always_comb begin
		idle_res = '0;
		if (req.kind == K_ADD_FILE) begin
			if (free_found) begin
				idle_res.status      = ST_OK;
				idle_res.slot_taken  = SLOT_W'(free_slot);
				idle_res.slot_in_use = 1'b1;
			end else begin
				idle_res.status = ST_FULL;
			end
		end else if (!slot_ok) begin
			idle_res.status = ST_INVALID;
		end
	end

	// Word analysis for the first-fit scan.
	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			free_w[k] = !bm_rd[k] && ((int'(pw_s1) * WORD_W + k) < NUM_BLOCKS);
		end
		tz = CNT_W'(WORD_W);
		for (int k = WORD_W - 1; k >= 0; k--) begin
			if (!free_w[k]) tz = CNT_W'(k);
		end
		lz = CNT_W'(WORD_W);
		for (int k = 0; k < WORD_W; k++) begin
			if (!free_w[k]) lz = CNT_W'(WORD_W - 1 - k);
		end
		nmask = ((WORD_W+1)'(1) << need_q[CNT_W-1:0]) - (WORD_W+1)'(1);
		win_hit = 1'b0;
		win_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (((free_w >> i) & nmask[WORD_W-1:0]) == nmask[WORD_W-1:0]) begin
				win_hit = 1'b1;
				win_pos = WOFF_W'(i);
			end
		end
		if (need_q > NEED_W'(WORD_W)) win_hit = 1'b0;
		word_base = BI_W'(pw_s1) << WOFF_W;
		scan_found = 1'b1;
		scan_start = word_base + BI_W'(win_pos);
		if ((SUM_W'(run_q) + SUM_W'(tz)) >= SUM_W'(need_q)) begin
			scan_start = (run_q != '0) ? rstart_q : word_base;
		end else if (!win_hit) begin
			scan_found = 1'b0;
		end
		scan_last = (pw_s1 == WA_W'(WORDS - 1));
	end

	assign refs_dec   = slot_rd_q.refs - REFS_W'(1);
	assign last_close = (slot_rd_q.refs == REFS_W'(1));
	always_comb begin
		close_hi = SUM_W'(slot_rd_q.start) + SUM_W'(blocks_for(slot_rd_q.bytes));
		if (close_hi > SUM_W'(NUM_BLOCKS)) close_hi = SUM_W'(NUM_BLOCKS);
	end

	// Range mask of the bitmap word being marked or freed.
	always_comb begin
		lo_w   = WA_W'(lo_q >> WOFF_W);
		hi_w   = WA_W'((hi_q - SUM_W'(1)) >> WOFF_W);
		lo_off = (rw_q == lo_w) ? CNT_W'(lo_q[WOFF_W-1:0]) : '0;
		hi_off = (rw_q == hi_w) ? (CNT_W'((hi_q - SUM_W'(1)) & SUM_W'(WORD_W - 1))
			+ CNT_W'(1)) : CNT_W'(WORD_W);
		rmask = (((WORD_W+1)'(1) << hi_off) - (WORD_W+1)'(1))
			& ~(((WORD_W+1)'(1) << lo_off) - (WORD_W+1)'(1));
		rng_last = (rw_q == hi_w);
		bm_wd = set_q ? (bm_rd | rmask[WORD_W-1:0]) : (bm_rd & ~rmask[WORD_W-1:0]);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.kind)
						K_ALLOC:                   state_d = S_SCAN;
						K_ADD_FILE:                state_d = S_DONE;
						K_ADD_REF, K_CLOSE, K_READ: state_d = slot_ok ? S_SLOT : S_DONE;
						default:                   state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (pv_s1 && scan_found) begin
					state_d = S_RNG_RD;
				end else if (pv_s1 && scan_last) begin
					state_d = S_DONE;
				end
			end
			S_SLOT: begin
				if (kind_q == K_CLOSE && slot_rd_q.refs != '0 && last_close &&
					int'(slot_rd_q.start) < NUM_BLOCKS) begin
					state_d = S_RNG_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RNG_RD: state_d = S_RNG_WR;
			S_RNG_WR: state_d = rng_last ? S_DONE : S_RNG_RD;
			S_DONE: begin
				if (!out_v_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready      = (state_q == S_IDLE);
		bm_ctl         = '0;
		slot_we        = 1'b0;
		slot_wa        = slot_q;
		slot_wd        = slot_rd_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.kind == K_ADD_FILE && free_found) begin
					slot_we       = 1'b1;
					slot_wa       = free_slot;
					slot_wd.inode = req.inode;
					slot_wd.start = req.start_block;
					slot_wd.bytes = req.byte_size;
					slot_wd.refs  = '0;
				end
			end
			S_SCAN: begin
				bm_ctl.rd_en   = (int'(issue_q) < WORDS);
				bm_ctl.rd_addr = issue_q[WA_W-1:0];
			end
			S_SLOT: begin
				if (kind_q == K_ADD_REF) begin
					slot_we      = 1'b1;
					slot_wd.refs = (slot_rd_q.refs == '1) ? slot_rd_q.refs
						: slot_rd_q.refs + REFS_W'(1);
				end else if (kind_q == K_CLOSE && slot_rd_q.refs != '0) begin
					slot_we      = 1'b1;
					slot_wd.refs = refs_dec;
				end
			end
			S_RNG_RD: begin
				bm_ctl.rd_en   = 1'b1;
				bm_ctl.rd_addr = rw_q;
			end
			S_RNG_WR: begin
				bm_ctl.wr_en   = 1'b1;
				bm_ctl.wr_addr = rw_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (accept) begin
			slot_rd_q <= slot_mem[SA_W'(req.slot_index)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q  <= '0;
			sv_q    <= '0;
			out_v_q <= 1'b0;
			pv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) base_q <= cfg_wdata;
			if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
				out_v_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			if (slot_we && state_q == S_IDLE) begin
				sv_q[slot_wa] <= 1'b1;
			end
			if (state_q == S_SLOT && kind_q == K_CLOSE && slot_rd_q.refs != '0 &&
				last_close) begin
				sv_q[slot_q] <= 1'b0;
			end
			if (state_q == S_SCAN) begin
				pv_s1 <= bm_ctl.rd_en;
			end else begin
				pv_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_v_q || rsp.ready)) begin
			out_q <= res_q;
		end
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q   <= kind_t'(req.kind);
					slot_q   <= SA_W'(req.slot_index);
					need_q   <= blocks_for(req.byte_size);
					run_q    <= '0;
					rstart_q <= '0;
					issue_q  <= '0;
					res_q    <= idle_res;
				end
			end
			S_SCAN: begin
				if (int'(issue_q) < WORDS) issue_q <= issue_q + (WA_W+1)'(1);
				pw_s1 <= issue_q[WA_W-1:0];
				if (pv_s1) begin
					if (scan_found) begin
						lo_q  <= SUM_W'(scan_start);
						hi_q  <= SUM_W'(scan_start) + SUM_W'(need_q);
						rw_q  <= WA_W'(scan_start >> WOFF_W);
						set_q <= 1'b1;
						res_q.status         <= ST_OK;
						res_q.found_block    <= BLK_W'(scan_start);
						res_q.buffer_address <= base_q
							| (ADDR_W'(BLK_W'(scan_start)) << BB_LOG);
					end else if (scan_last) begin
						res_q.status <= ST_NO_SPACE;
					end else if (tz == CNT_W'(WORD_W)) begin
						if (run_q == '0) rstart_q <= word_base;
						run_q <= run_q + NEED_W'(WORD_W);
					end else begin
						run_q    <= NEED_W'(lz);
						rstart_q <= word_base + BI_W'(CNT_W'(WORD_W) - lz);
					end
				end
			end
			S_SLOT: begin
				case (kind_q)
					K_ADD_REF: begin
						res_q.status      <= ST_OK;
						res_q.slot_in_use <= 1'b1;
						res_q.slot_refs   <= (slot_rd_q.refs == '1) ? slot_rd_q.refs
							: slot_rd_q.refs + REFS_W'(1);
					end
					K_CLOSE: begin
						if (slot_rd_q.refs == '0) begin
							res_q.status      <= ST_INVALID;
							res_q.slot_in_use <= 1'b1;
						end else if (last_close) begin
							res_q.status <= ST_OK;
							lo_q  <= SUM_W'(slot_rd_q.start);
							hi_q  <= close_hi;
							rw_q  <= WA_W'(slot_rd_q.start >> WOFF_W);
							set_q <= 1'b0;
						end else begin
							res_q.status      <= ST_REFERENCED;
							res_q.slot_in_use <= 1'b1;
							res_q.slot_refs   <= refs_dec;
						end
					end
					default: begin
						res_q.status         <= ST_OK;
						res_q.slot_in_use    <= 1'b1;
						res_q.found_block    <= slot_rd_q.start;
						res_q.buffer_address <= base_q
							| (ADDR_W'(slot_rd_q.start) << BB_LOG);
						res_q.slot_inode     <= slot_rd_q.inode;
						res_q.slot_bytes     <= slot_rd_q.bytes;
						res_q.slot_refs      <= slot_rd_q.refs;
					end
				endcase
			end
			S_RNG_WR: begin
				rw_q <= rw_q + WA_W'(1);
			end
			default: ;
		endcase
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_q.status;
	assign rsp.found_block    = out_q.found_block;
	assign rsp.buffer_address = out_q.buffer_address;
	assign rsp.slot_taken     = out_q.slot_taken;
	assign rsp.slot_inode     = out_q.slot_inode;
	assign rsp.slot_bytes     = out_q.slot_bytes;
	assign rsp.slot_refs      = out_q.slot_refs;
	assign rsp.slot_in_use    = out_q.slot_in_use;

endmodule

@@ tb/fstba_tb_checker.sv @@
// ----------------------------------------------------------------------------
// fstba_tb_checker
// Watches the request and result channels of the file slot table, keeps its
// own copy of the bitmap, the slots and the base register, and compares each
// result transfer field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module fstba_tb_checker
	import fstba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [47:0] cfg_wdata,
	fstba_req_if        req,
	fstba_rsp_if        rsp,
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [47:0]        base_addr;
	logic               busy_map [NUM_BLOCKS];
	logic               used [SLOTS];
	logic [31:0]        inode_tab [SLOTS];
	logic [11:0]        start_tab [SLOTS];
	logic [24:0]        bytes_tab [SLOTS];
	logic [15:0]        refs_tab [SLOTS];
	result_t            expected_results [$];

	function automatic int block_count(logic [24:0] b);
		int n;
		n = (int'(b) + BLOCK_BYTES - 1) / BLOCK_BYTES;
		return (n == 0) ? 1 : n;
	endfunction

	function automatic logic [47:0] addr_of(logic [11:0] blk);
		logic [47:0] off;
		off = 48'(blk) * 48'(BLOCK_BYTES);
		return base_addr | off;
	endfunction

	task automatic predict_request();
		result_t r;
		int need;
		int run;
		int run_start;
		int found;
		logic [5:0] s;
		r = '0;
		s = req.slot_index;
		case (req.kind)
			K_ALLOC: begin
				need = block_count(req.byte_size);
				run = 0;
				run_start = 0;
				found = 0;
				for (int b = 0; b < NUM_BLOCKS && !found; b++) begin
					if (busy_map[b]) begin
						run = 0;
					end else begin
						if (run == 0) run_start = b;
						run++;
						if (run >= need) found = 1;
					end
				end
				if (found) begin
					for (int b = run_start; b < run_start + need; b++) busy_map[b] = 1'b1;
					r.status = ST_OK;
					r.found_block = 12'(run_start);
					r.buffer_address = addr_of(12'(run_start));
				end else begin
					r.status = ST_NO_SPACE;
				end
			end
			K_ADD_FILE: begin
				r.status = ST_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!used[i]) begin
						used[i] = 1'b1;
						inode_tab[i] = req.inode;
						start_tab[i] = req.start_block;
						bytes_tab[i] = req.byte_size;
						refs_tab[i] = '0;
						r.status = ST_OK;
						r.slot_taken = 6'(i);
						r.slot_in_use = 1'b1;
						break;
					end
				end
			end
			K_ADD_REF, K_CLOSE, K_READ: begin
				if (!used[s]) begin
					r.status = ST_INVALID;
				end else if (req.kind == K_ADD_REF) begin
					if (refs_tab[s] != 16'hFFFF) refs_tab[s]++;
					r.status = ST_OK;
					r.slot_refs = refs_tab[s];
					r.slot_in_use = 1'b1;
				end else if (req.kind == K_CLOSE) begin
					if (refs_tab[s] == 0) begin
						r.status = ST_INVALID;
						r.slot_in_use = 1'b1;
					end else begin
						refs_tab[s]--;
						if (refs_tab[s] == 0) begin
							need = block_count(bytes_tab[s]);
							for (int b = start_tab[s]; b < start_tab[s] + need && b < NUM_BLOCKS;
								b++) busy_map[b] = 1'b0;
							used[s] = 1'b0;
							r.status = ST_OK;
						end else begin
							r.status = ST_REFERENCED;
							r.slot_refs = refs_tab[s];
							r.slot_in_use = 1'b1;
						end
					end
				end else begin
					r.status = ST_OK;
					r.found_block = start_tab[s];
					r.buffer_address = addr_of(start_tab[s]);
					r.slot_inode = inode_tab[s];
					r.slot_bytes = bytes_tab[s];
					r.slot_refs = refs_tab[s];
					r.slot_in_use = 1'b1;
				end
			end
			default: return;
		endcase
		expected_results.push_back(r);
	endtask

	task automatic compare_result();
		result_t e;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("Unexpected result transfer, status %0d.", rsp.status);
			return;
		end
		e = expected_results.pop_front();
		if (rsp.status !== e.status || rsp.found_block !== e.found_block
			|| rsp.buffer_address !== e.buffer_address || rsp.slot_taken !== e.slot_taken
			|| rsp.slot_inode !== e.slot_inode || rsp.slot_bytes !== e.slot_bytes
			|| rsp.slot_refs !== e.slot_refs || rsp.slot_in_use !== e.slot_in_use) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("Mismatch: expected st=%0d blk=%0d addr=%h tk=%0d ino=%h by=%0d ref=%0d u=%0d",
					e.status, e.found_block, e.buffer_address, e.slot_taken, e.slot_inode,
					e.slot_bytes, e.slot_refs, e.slot_in_use);
				$display("          actual   st=%0d blk=%0d addr=%h tk=%0d ino=%h by=%0d ref=%0d u=%0d",
					rsp.status, rsp.found_block, rsp.buffer_address, rsp.slot_taken,
					rsp.slot_inode, rsp.slot_bytes, rsp.slot_refs, rsp.slot_in_use);
			end
		end
	endtask

	initial begin
		mismatches = 0;
		pending = 0;
		base_addr = '0;
		for (int b = 0; b < NUM_BLOCKS; b++) busy_map[b] = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			used[i] = 1'b0;
			refs_tab[i] = '0;
			inode_tab[i] = '0;
			start_tab[i] = '0;
			bytes_tab[i] = '0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) base_addr <= cfg_wdata;
			if (rsp.valid && rsp.ready) compare_result();
			if (req.valid && req.ready) predict_request();
			pending <= expected_results.size();
		end
	end
endmodule

@@ tb/tb_file_slot_table_with_block_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_file_slot_table_with_block_allocator
// Drives directed and random requests into the slot table with random idle
// cycles on both channels, rewrites the base register between phases, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_file_slot_table_with_block_allocator;
	import fstba_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [47:0] cfg_wdata = '0;
	int          mismatches;
	int          pending;
	int          cycles = 0;
	bit          no_idle = 1'b0;
	int          open_slots [$];

	fstba_req_if req();
	fstba_rsp_if rsp();

	file_slot_table_with_block_allocator u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp)
	);

	fstba_tb_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp), .mismatches(mismatches), .pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.kind = '0;
		req.byte_size = '0;
		req.start_block = '0;
		req.inode = '0;
		req.slot_index = '0;
		rsp.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) rsp.ready <= no_idle || ($urandom_range(99) >= 9);
	end

	// The valid line stays high after a transfer; the next send, an idle cycle
	// or a drain takes it down or reloads it at that same edge.
	task automatic send(logic [2:0] k, logic [24:0] by, logic [11:0] st, logic [31:0] ino,
		logic [5:0] sl);
		while (!no_idle && $urandom_range(99) < 9) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind <= k;
		req.byte_size <= by;
		req.start_block <= st;
		req.inode <= ino;
		req.slot_index <= sl;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		int w;
		w = 0;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		while (w < 200) begin
			@(posedge clk);
			w++;
		end
	endtask

	task automatic write_base(logic [47:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n);
		int p;
		int sl;
		logic [24:0] by;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(99);
			by = ($urandom_range(19) == 0) ? 25'($urandom) : 25'($urandom_range(20000));
			if (p < 22) begin
				send(K_ALLOC, by, '0, $urandom, 6'($urandom));
			end else if (p < 40) begin
				send(K_ADD_FILE, by, 12'($urandom), $urandom, 6'($urandom));
			end else if (p < 85) begin
				sl = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(15);
				send(3'($urandom_range(K_ADD_REF, K_READ)), by, 12'($urandom), $urandom, 6'(sl));
			end else if (p < 97) begin
				send(K_CLOSE, '0, '0, '0, 6'($urandom_range(15)));
			end else begin
				send(3'($urandom_range(5, 7)), by, 12'($urandom), $urandom, 6'($urandom));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_base(48'hFFFF_FFFF_FFFF);
		send(K_ALLOC, 25'd0, '0, '0, '0);
		send(K_ALLOC, 25'd1, '0, '0, '0);
		send(K_ALLOC, 25'd4096, '0, '0, '0);
		send(K_ALLOC, 25'd4097, '0, '0, '0);
		send(K_ALLOC, 25'h1000000, '0, '0, '0);
		send(K_ALLOC, 25'h1FFFFFF, '0, '0, '0);
		send(K_READ, '0, '0, '0, 6'd0);
		send(K_CLOSE, '0, '0, '0, 6'd63);
		send(K_ADD_FILE, 25'd0, 12'd0, 32'hFFFF_FFFF, '0);
		send(K_ADD_FILE, 25'h1FFFFFF, 12'hFFF, 32'd0, '0);
		send(K_CLOSE, '0, '0, '0, 6'd0);
		send(K_ADD_REF, '0, '0, '0, 6'd0);
		send(K_ADD_REF, '0, '0, '0, 6'd0);
		send(K_READ, '0, '0, '0, 6'd1);
		send(K_CLOSE, '0, '0, '0, 6'd0);
		send(K_CLOSE, '0, '0, '0, 6'd0);
		send(K_ADD_REF, '0, '0, '0, 6'd1);
		send(K_CLOSE, '0, '0, '0, 6'd1);
		send(3'd5, '0, '0, '0, '0);
		send(3'd7, '0, '0, '0, '0);
		write_base(48'h0);
		for (int i = 0; i < 66; i++) send(K_ADD_FILE, 25'($urandom), 12'($urandom), $urandom, '0);
		for (int i = 0; i < 64; i++) send(K_READ, '0, '0, '0, 6'(i));
		for (int i = 0; i < 64; i++) begin
			send(K_ADD_REF, '0, '0, '0, 6'(i));
			send(K_CLOSE, '0, '0, '0, 6'(i));
		end
		write_base(48'h0000_0123_4567);
		no_idle = 1'b1;
		random_phase(70);
		no_idle = 1'b0;
		write_base(48'($urandom) << 16 | 48'($urandom));
		random_phase(100);
		drain();
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
